[rtl/imh_pkg.sv]
// ----------------------------------------------------------------------------
// imh_pkg
// Types and constants shared by the indexed min-heap block.
// ----------------------------------------------------------------------------
`default_nettype none
package imh_pkg;
	localparam int NumKeys  = 4096;
	localparam int KeyW     = $clog2(NumKeys);
	localparam int CountW   = KeyW + 1;
	localparam int CostW    = 32;

	typedef logic [KeyW-1:0]   key_t;
	typedef logic [KeyW-1:0]   slot_t;
	typedef logic [CountW-1:0] count_t;
	typedef logic [CostW-1:0]  cost_t;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_DEC  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] operation;
		key_t       key;
		cost_t      cost;
	} req_t;

	typedef struct packed {
		key_t       popped_key;
		logic [1:0] status;
		count_t     entry_count;
	} rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_PUSH_WR,
		S_DEC_RD,
		S_DEC_SLOT,
		S_DEC_CHK,
		S_POP_RD,
		S_POP_LAST,
		S_POP_WR,
		S_DN_COST,
		S_DN_CHK,
		S_DN_K1,
		S_DN_C1,
		S_DN_K2,
		S_DN_C2,
		S_DN_DEC,
		S_UP_RD,
		S_UP_KEY,
		S_UP_CMP,
		S_SWAP_A,
		S_SWAP_B,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

[rtl/imh_if.sv]
// ----------------------------------------------------------------------------
// imh_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface imh_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/imh_ram.sv]
// ----------------------------------------------------------------------------
// imh_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module imh_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output      logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

[rtl/indexed_min_heap_decrease_key.sv]
// Empty pop, full push and unused op go straight to the result. A sift level
// runs as a sequence of states over the single-port slot, position and cost
// memories, shared by one compare unit. One item at a time; the next
// transfer is taken the cycle after the result transfer.
// Reset clears the entry count and sequencer; memories are not cleared.
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key
// Indexed binary min-heap with push, pop and decrease-key.
// ----------------------------------------------------------------------------
`default_nettype none
module indexed_min_heap_decrease_key
	import imh_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	imh_if.sink      in_ch,
	imh_if.source    out_ch
);
	state_t st_q, st_d;
	count_t size_q, size_d;
	req_t   req_q;
	slot_t  pos_q, pos_d, oth_q, oth_d, best_q, best_d, c2_q, c2_d;
	key_t   kpos_q, kpos_d, koth_q, koth_d, kbest_q, kbest_d;
	cost_t  cpos_q, cpos_d, cbest_q, cbest_d;
	logic   is_dec_q, is_dec_d, dn_q, dn_d, two_q, two_d;
	key_t   popped_q, popped_d;
	logic [1:0] status_q, status_d;
	logic   out_v_q;

	logic  hs_we, sk_we, kc_we;
	slot_t hs_a, sk_a;
	key_t  kc_a, hs_wd;
	slot_t sk_wd;
	cost_t kc_wd;
	key_t  hs_rd;
	slot_t sk_rd;
	cost_t kc_rd;

	imh_ram #(.Width(KeyW), .Depth(NumKeys)) u_hs (.clk, .we(hs_we), .addr(hs_a),
		.wdata(hs_wd), .rdata(hs_rd));
	imh_ram #(.Width(KeyW), .Depth(NumKeys)) u_sk (.clk, .we(sk_we), .addr(sk_a),
		.wdata(sk_wd), .rdata(sk_rd));
	imh_ram #(.Width(CostW), .Depth(NumKeys)) u_kc (.clk, .we(kc_we), .addr(kc_a),
		.wdata(kc_wd), .rdata(kc_rd));

	assign in_ch.ready = (st_q == S_IDLE) && !out_v_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = '{popped_key: popped_q, status: status_q, entry_count: size_q};

	logic [CountW:0] c1w, c2w;
	slot_t par_w;
	assign c1w = {1'b0, pos_q, 1'b1};
	assign c2w = {1'b0, pos_q, 1'b0} + (CountW+1)'(2);
	assign par_w = (pos_q - slot_t'(1)) >> 1;

	always_comb begin
		st_d = st_q; size_d = size_q; pos_d = pos_q; oth_d = oth_q; best_d = best_q;
		c2_d = c2_q; kpos_d = kpos_q; koth_d = koth_q; kbest_d = kbest_q;
		cpos_d = cpos_q; cbest_d = cbest_q; is_dec_d = is_dec_q; dn_d = dn_q;
		two_d = two_q; popped_d = popped_q; status_d = status_q;
		hs_we = 1'b0; sk_we = 1'b0; kc_we = 1'b0;
		hs_a = pos_q; sk_a = req_q.key; kc_a = req_q.key;
		hs_wd = req_q.key; sk_wd = pos_q; kc_wd = req_q.cost;
		unique case (st_q)
			S_IDLE: begin
				if (in_ch.valid && in_ch.ready) begin
					popped_d = '0; status_d = ST_OK; st_d = S_DONE;
					unique case (op_t'(in_ch.data.operation))
						OP_PUSH: begin
							if (size_q == count_t'(NumKeys)) status_d = ST_FULL;
							else begin
								pos_d = size_q[KeyW-1:0]; is_dec_d = 1'b0; dn_d = 1'b0;
								st_d = S_PUSH_WR;
							end
						end
						OP_POP: begin
							if (size_q == '0) status_d = ST_EMPTY;
							else begin
								dn_d = 1'b1; st_d = S_POP_RD;
							end
						end
						OP_DEC: begin
							is_dec_d = 1'b1; dn_d = 1'b0; st_d = S_DEC_RD;
						end
						OP_NONE: ;
					endcase
				end
			end
			S_PUSH_WR: begin
				hs_we = 1'b1; sk_we = 1'b1; kc_we = 1'b1;
				size_d = size_q + count_t'(1);
				kpos_d = req_q.key; cpos_d = req_q.cost;
				st_d = S_UP_RD;
			end
			S_DEC_RD: begin
				st_d = S_DEC_SLOT;
			end
			S_DEC_SLOT: begin
				pos_d = sk_rd; cpos_d = kc_rd; hs_a = sk_rd; st_d = S_DEC_CHK;
			end
			S_DEC_CHK: begin
				st_d = S_DONE;
				if ({1'b0, pos_q} < size_q && hs_rd == req_q.key
					&& req_q.cost < cpos_q) begin
					kc_we = 1'b1; cpos_d = req_q.cost; kpos_d = req_q.key;
					st_d = S_UP_RD;
				end
			end
			S_POP_RD: begin
				hs_a = '0; st_d = S_POP_LAST;
			end
			S_POP_LAST: begin
				popped_d = hs_rd; hs_a = slot_t'(size_q - count_t'(1)); st_d = S_POP_WR;
			end
			S_POP_WR: begin
				kpos_d = hs_rd;
				hs_we = 1'b1; hs_a = '0; hs_wd = hs_rd;
				sk_we = 1'b1; sk_a = hs_rd; sk_wd = '0;
				kc_a = hs_rd;
				size_d = size_q - count_t'(1); pos_d = '0;
				st_d = S_DN_COST;
			end
			S_DN_COST: begin
				cpos_d = kc_rd; st_d = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (c1w < {1'b0, size_q}) begin
					two_d = c2w < {1'b0, size_q};
					c2_d = c2w[KeyW-1:0];
					best_d = pos_q; kbest_d = kpos_q; cbest_d = cpos_q;
					hs_a = c1w[KeyW-1:0]; oth_d = c1w[KeyW-1:0];
					st_d = S_DN_K1;
				end else st_d = S_DONE;
			end
			S_DN_K1: begin
				koth_d = hs_rd; kc_a = hs_rd; st_d = S_DN_C1;
			end
			S_DN_C1: begin
				if (cbest_q >= kc_rd) begin
					best_d = oth_q; kbest_d = koth_q; cbest_d = kc_rd;
				end
				if (two_q) begin
					hs_a = c2_q; oth_d = c2_q; st_d = S_DN_K2;
				end else st_d = S_DN_DEC;
			end
			S_DN_K2: begin
				koth_d = hs_rd; kc_a = hs_rd; st_d = S_DN_C2;
			end
			S_DN_C2: begin
				if (cbest_q >= kc_rd) begin
					best_d = oth_q; kbest_d = koth_q; cbest_d = kc_rd;
				end
				st_d = S_DN_DEC;
			end
			S_DN_DEC: begin
				st_d = (best_q != pos_q) ? S_SWAP_A : S_DONE;
			end
			S_UP_RD: begin
				if (pos_q == '0) st_d = S_DONE;
				else begin
					oth_d = par_w; hs_a = par_w; st_d = S_UP_KEY;
				end
			end
			S_UP_KEY: begin
				koth_d = hs_rd; kc_a = hs_rd; st_d = S_UP_CMP;
			end
			S_UP_CMP: begin
				if (kc_rd > cpos_q || (!is_dec_q && kc_rd == cpos_q)) begin
					best_d = oth_q; kbest_d = koth_q; st_d = S_SWAP_A;
				end else st_d = S_DONE;
			end
			// upper slot is written first, so a repeated key ends on the lower one
			S_SWAP_A: begin
				hs_we = 1'b1; sk_we = 1'b1;
				if (dn_q) begin
					hs_a = pos_q; hs_wd = kbest_q; sk_a = kbest_q; sk_wd = pos_q;
				end else begin
					hs_a = best_q; hs_wd = kpos_q; sk_a = kpos_q; sk_wd = best_q;
				end
				st_d = S_SWAP_B;
			end
			S_SWAP_B: begin
				hs_we = 1'b1; sk_we = 1'b1;
				if (dn_q) begin
					hs_a = best_q; hs_wd = kpos_q; sk_a = kpos_q; sk_wd = best_q;
				end else begin
					hs_a = pos_q; hs_wd = kbest_q; sk_a = kbest_q; sk_wd = pos_q;
				end
				pos_d = best_q;
				st_d = dn_q ? S_DN_CHK : S_UP_RD;
			end
			S_DONE: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; size_q <= '0; out_v_q <= 1'b0;
		end else begin
			st_q <= st_d; size_q <= size_d;
			if (st_q == S_DONE) out_v_q <= 1'b1;
			else if (out_ch.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) req_q <= in_ch.data;
		pos_q <= pos_d; oth_q <= oth_d; best_q <= best_d; c2_q <= c2_d;
		kpos_q <= kpos_d; koth_q <= koth_d; kbest_q <= kbest_d;
		cpos_q <= cpos_d; cbest_q <= cbest_d; is_dec_q <= is_dec_d; dn_q <= dn_d;
		two_q <= two_d; popped_q <= popped_d; status_q <= status_d;
	end
endmodule
`default_nettype wire
